>>> hw/rtl/pff_pkg.sv
// ----------------------------------------------------------------------------
// pff_pkg
// Shared types for the two-objective Pareto frontier filter: the stored entry
// layout and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pff_pkg;

	localparam int unsigned FIELD_W = 32;

	// Packed so that apex_first lands in the lowest bits, matching tdata.
	typedef struct packed {
		logic [FIELD_W-1:0] cost_second;
		logic [FIELD_W-1:0] cost_first;
		logic [FIELD_W-1:0] apex_second;
		logic [FIELD_W-1:0] apex_first;
	} entry_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept;   // a loading request is taken this cycle
		logic step;     // consume the head cell and shift the chain down
		logic capture;  // load the head cell into the output register
		logic clear;    // set closed: empty the chain and the trackers
	} pff_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic head_keep;  // head cell is on the frontier
		logic head_last;  // head cell is the final frontier entry
	} pff_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/pff_datapath.sv
// ----------------------------------------------------------------------------
// pff_datapath
// Sorted insertion chain, minimum trackers and output payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module pff_datapath #(
	parameter int unsigned SET_SIZE   = 32,
	parameter int unsigned COST_WIDTH = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pff_pkg::pff_cmd_t cmd,
	output pff_pkg::pff_sts_t    sts,
	input  wire pff_pkg::entry_t new_entry,
	output pff_pkg::entry_t      out_entry,
	output logic                 out_overflow
);

	localparam int unsigned CW = (COST_WIDTH < pff_pkg::FIELD_W) ? COST_WIDTH
	                                                           : pff_pkg::FIELD_W;
	localparam logic [pff_pkg::FIELD_W-1:0] COST_MASK =
		{pff_pkg::FIELD_W{1'b1}} >> (pff_pkg::FIELD_W - CW);

	pff_pkg::entry_t cell_q  [SET_SIZE];
	logic [SET_SIZE-1:0] valid_q;
	logic [SET_SIZE-1:0] ins;
	pff_pkg::entry_t masked;
	logic full;
	logic insert;

	logic                        overflow_q;
	logic                        have_best_q;
	logic [pff_pkg::FIELD_W-1:0] best_a1_q;
	logic [pff_pkg::FIELD_W-1:0] best_a2_q;
	logic                        have_scan_q;
	logic [pff_pkg::FIELD_W-1:0] scan_min_q;
	logic                        better;

	always_comb begin
		masked             = new_entry;
		masked.cost_first  = new_entry.cost_first & COST_MASK;
		masked.cost_second = new_entry.cost_second & COST_MASK;
	end

	assign full   = valid_q[SET_SIZE-1];
	assign insert = cmd.accept && !full;

	// A cell opens for the new entry when it is empty or holds an entry the
	// new one strictly precedes; equal keys leave the earlier arrival first.
	for (genvar i = 0; i < SET_SIZE; i++) begin : g_cell
		assign ins[i] = !valid_q[i]
			|| (masked.apex_first < cell_q[i].apex_first)
			|| ((masked.apex_first == cell_q[i].apex_first)
			    && (masked.apex_second < cell_q[i].apex_second));

		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (insert && ins[0]) begin
					cell_q[0] <= masked;
				end else if (cmd.step) begin
					cell_q[0] <= cell_q[1];
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_q[0] <= 1'b0;
				end else if (cmd.clear) begin
					valid_q[0] <= 1'b0;
				end else if (insert) begin
					valid_q[0] <= 1'b1;
				end else if (cmd.step) begin
					valid_q[0] <= valid_q[1];
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (insert && ins[i]) begin
					cell_q[i] <= ins[i-1] ? cell_q[i-1] : masked;
				end else if (cmd.step) begin
					if (i == SET_SIZE - 1) begin
						cell_q[i] <= cell_q[i];
					end else begin
						cell_q[i] <= cell_q[(i + 1) % SET_SIZE];
					end
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_q[i] <= 1'b0;
				end else if (cmd.clear) begin
					valid_q[i] <= 1'b0;
				end else if (insert) begin
					valid_q[i] <= valid_q[i] | valid_q[i-1];
				end else if (cmd.step) begin
					if (i == SET_SIZE - 1) begin
						valid_q[i] <= 1'b0;
					end else begin
						valid_q[i] <= valid_q[(i + 1) % SET_SIZE];
					end
				end
			end
		end
	end

	// The final frontier entry is the earliest sorted entry with the least
	// second apex: least second apex, then least first apex, first arrival.
	assign better = !have_best_q
		|| (masked.apex_second < best_a2_q)
		|| ((masked.apex_second == best_a2_q) && (masked.apex_first < best_a1_q));

	assign sts.head_keep = !have_scan_q || (cell_q[0].apex_second < scan_min_q);
	assign sts.head_last = sts.head_keep && (cell_q[0].apex_second == best_a2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_q  <= 1'b0;
			have_best_q <= 1'b0;
			have_scan_q <= 1'b0;
		end else if (cmd.clear) begin
			overflow_q  <= 1'b0;
			have_best_q <= 1'b0;
			have_scan_q <= 1'b0;
		end else begin
			if (cmd.accept && full) begin
				overflow_q <= 1'b1;
			end
			if (insert && better) begin
				have_best_q <= 1'b1;
			end
			if (cmd.step && sts.head_keep) begin
				have_scan_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (insert && better) begin
			best_a1_q <= masked.apex_first;
			best_a2_q <= masked.apex_second;
		end
		if (cmd.step && sts.head_keep) begin
			scan_min_q <= cell_q[0].apex_second;
		end
		if (cmd.capture) begin
			out_entry    <= cell_q[0];
			out_overflow <= overflow_q;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/pff_ctrl.sv
// ----------------------------------------------------------------------------
// pff_ctrl
// Controller: loading, frontier scan and hand-over of the final result.
// ----------------------------------------------------------------------------
`default_nettype none

module pff_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_last,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output pff_pkg::pff_cmd_t     cmd,
	input  wire pff_pkg::pff_sts_t sts
);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_LAST
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ST_LOAD);

	always_comb begin
		cmd.accept  = (state_q == ST_LOAD) && in_valid;
		cmd.step    = (state_q == ST_SCAN) && out_free;
		cmd.capture = cmd.step && sts.head_keep;
		cmd.clear   = (state_q == ST_LAST) && out_valid_q && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_valid && in_last) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (out_free) begin
						out_valid_q <= sts.head_keep;
						if (sts.head_last) begin
							state_q <= ST_LAST;
						end
					end
				end
				ST_LAST: begin
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/pareto_front_filter_biobjective.sv
// ----------------------------------------------------------------------------
// pareto_front_filter_biobjective
// Collects a set of two-objective entries and streams out its Pareto frontier
// in ascending order of the first apex.
// ----------------------------------------------------------------------------
//
//  Channel | Group     | Carries
//  --------+-----------+-------------------------------------------------------
//  input   | s_axis_*  | tdata: apex pair and cost pair; tlast: closes the set
//  output  | m_axis_*  | tdata: kept apex and cost pair; tlast: final frontier
//          |           | entry; tuser: set overflowed
//
// Loading takes one request per cycle: each entry is placed at its sorted
// position in a chain of SET_SIZE cells in the same cycle, so no sort pass
// follows. After the closing request the chain is shifted out one cell per
// cycle; only frontier entries leave as output requests, and a stalled
// output stops the shift. The input is not ready from the closing request
// until the final frontier entry has been taken. Reset clears the cell
// valid bits at once, so the block is ready as soon as reset is released,
// with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pareto_front_filter_biobjective #(
	parameter int unsigned SET_SIZE   = 32,
	parameter int unsigned COST_WIDTH = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// apex_first [31:0], apex_second [63:32], cost_first [95:64],
	// cost_second [127:96]
	input  wire logic [127:0] s_axis_tdata,
	input  wire logic         s_axis_tlast,   // set_end
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// kept_apex_first [31:0], kept_apex_second [63:32],
	// kept_cost_first [95:64], kept_cost_second [127:96]
	output logic [127:0]      m_axis_tdata,
	output logic              m_axis_tlast,   // run_end
	output logic              m_axis_tuser    // overflowed
);

	pff_pkg::pff_cmd_t cmd;
	pff_pkg::pff_sts_t sts;
	pff_pkg::entry_t   new_entry;
	pff_pkg::entry_t   out_entry;
	logic              out_overflow;

	// The entry layout matches the tdata packing bit for bit.
	assign new_entry    = s_axis_tdata;
	assign m_axis_tdata = out_entry;
	assign m_axis_tuser = out_overflow;

	// The controller owns both handshakes and sequences the scan; the
	// datapath only follows its commands and reports on the head cell.
	pff_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_last   (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pff_datapath #(
		.SET_SIZE   (SET_SIZE),
		.COST_WIDTH (COST_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.new_entry    (new_entry),
		.out_entry    (out_entry),
		.out_overflow (out_overflow)
	);

	// Registered beside the payload: set when the final entry is captured.
	logic run_end_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			run_end_q <= sts.head_last;
		end
	end

	assign m_axis_tlast = run_end_q;

endmodule

`default_nettype wire

>>> tb/sv/tb_pareto_front_filter_biobjective.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pareto_front_filter_biobjective
// Self-checking bench for the two-objective Pareto frontier filter. A short
// table of directed sets is followed by about 500 random requests grouped into
// sets of varied size and value spread. Each accepted request is fed to a
// behavioural predictor of the frontier. Every output request is compared
// field by field with the oldest predicted result. Both sides idle and stall
// at random.
// ----------------------------------------------------------------------------

module tb_pareto_front_filter_biobjective;

	localparam int unsigned SET_SIZE    = 32;
	localparam int unsigned RANDOM_REQS = 500;
	localparam logic [31:0] MAXV        = 32'hFFFF_FFFF;

	// The ways in which the apex values of a random set are drawn.
	typedef enum int unsigned {
		SPREAD_FULL,     // any 32-bit value, so every bit toggles
		SPREAD_NARROW,   // a handful of values, so ties and duplicates abound
		SPREAD_EDGE,     // zero, all ones, single bits and the odd random value
		SPREAD_TRADEOFF  // second apex falls as the first rises: long frontiers
	} spread_t;

	// One frontier entry as it should leave the block.
	typedef struct {
		pff_pkg::entry_t ent;
		bit              run_end;
		bit              overflowed;
	} frontier_result_t;

	// A row of the directed table. The entry is sent reps times, cost_first
	// being XORed with the copy number; only the final copy carries last.
	// Where typed is set, the set closes with exactly one result, given here.
	typedef struct {
		logic [31:0] a1, a2, c1, c2;
		bit          last;
		int unsigned reps;
		bit          typed;
		logic [31:0] w_a1, w_a2, w_c1, w_c2;
		bit          w_ovf;
	} stim_row_t;

	localparam int unsigned N_ROWS = 21;

	stim_row_t directed_rows [N_ROWS] = '{
		// First set after reset: a lone entry of zeros.
		'{32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1, 1'b1,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		// A lone entry of all ones.
		'{MAXV, MAXV, MAXV, MAXV, 1'b1, 1, 1'b1,
		  MAXV, MAXV, MAXV, MAXV, 1'b0},
		// A mixed set: equal first apex, a dominated entry with an equal
		// second apex, a duplicate apex pair and both extremes.
		'{32'd10, 32'd20, 32'h1111_0001, 32'h2222_0001, 1'b0, 1, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{32'd5, 32'd30, 32'h1111_0002, 32'h2222_0002, 1'b0, 1, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{32'd5, 32'd25, 32'h1111_0003, 32'h2222_0003, 1'b0, 1, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{32'd7, 32'd25, 32'h1111_0004, 32'h2222_0004, 1'b0, 1, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{32'd12, 32'd10, 32'h1111_0005, 32'h2222_0005, 1'b0, 1, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{32'd12, 32'd10, 32'h1111_0006, 32'h2222_0006, 1'b0, 1, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{MAXV, 32'd0, 32'h1111_0007, 32'h2222_0007, 1'b0, 1, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{32'd1, MAXV, 32'h1111_0008, 32'h2222_0008, 1'b1, 1, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		// Fill the store with identical apex pairs, then close with a request
		// that is dropped: only the first copy survives, flagged as overflow.
		'{32'd100, 32'd200, 32'hC0DE_0000, 32'hBEEF_0000, 1'b0, SET_SIZE, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{32'd50, 32'd1, 32'h0000_0050, 32'h0000_0001, 1'b1, 1, 1'b1,
		  32'd100, 32'd200, 32'hC0DE_0000, 32'hBEEF_0000, 1'b1},
		// The overflow flag must not leak into the next set.
		'{32'd3, 32'd4, 32'd5, 32'd6, 1'b1, 1, 1'b1,
		  32'd3, 32'd4, 32'd5, 32'd6, 1'b0},
		// Arrival order opposite to sorted order, every entry on the frontier.
		'{32'd3, 32'd1, 32'h0000_0031, 32'h0000_0013, 1'b0, 1, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{32'd2, 32'd2, 32'h0000_0022, 32'h0000_0022, 1'b0, 1, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{32'd1, 32'd3, 32'h0000_0013, 32'h0000_0031, 1'b1, 1, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		// Equal first apex: only the smallest second apex is kept.
		'{32'd8, 32'd9, 32'h0000_0089, 32'h0, 1'b0, 1, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{32'd8, 32'd2, 32'h0000_0082, 32'h0, 1'b0, 1, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{32'd8, 32'd5, 32'h0000_0085, 32'h0, 1'b1, 1, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		// Identical apex pairs with different costs: the earlier arrival wins.
		'{32'd6, 32'd6, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1, 1'b0,
		  32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{32'd6, 32'd6, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1, 1'b1,
		  32'd6, 32'd6, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0}
	};

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic [127:0] s_tdata  = '0;
	logic         s_tlast  = 1'b0;
	logic         m_tready = 1'b0;
	wire          s_axis_tready;
	wire          m_axis_tvalid;
	wire  [127:0] m_axis_tdata;
	wire          m_axis_tlast;
	wire          m_axis_tuser;

	pareto_front_filter_biobjective #(
		.SET_SIZE  (SET_SIZE),
		.COST_WIDTH(32)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_tdata),
		.s_axis_tlast (s_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: the entries of the open set and whether any were lost.
	pff_pkg::entry_t  held_entries [$];
	bit               held_overflow;
	frontier_result_t frontier_due [$];

	// When set, neither side inserts idle cycles.
	bit          steady;
	int unsigned mismatches;
	int unsigned requests_sent;
	int unsigned sets_closed;
	int unsigned overflow_sets;
	int unsigned results_seen;

	function automatic int unsigned draw_wait();
		return steady ? 0 : $urandom_range(0, 5);
	endfunction

	function automatic logic [31:0] draw_apex(spread_t spread);
		case (spread)
			SPREAD_NARROW: return $urandom_range(0, 7);
			SPREAD_EDGE: begin
				case ($urandom_range(0, 3))
					0: return 32'h0;
					1: return MAXV;
					2: return 32'h1 << $urandom_range(0, 31);
					default: return $urandom;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Takes one accepted request into the open set. A closing request sorts
	// the set stably by first then second apex, walks it keeping each entry
	// whose second apex undercuts every entry kept so far, and queues the
	// resulting frontier. With log_results clear the frontier is worked out
	// but not queued, because a typed expectation stands in for it.
	function automatic void absorb_entry(pff_pkg::entry_t ent, bit closes,
			bit log_results);
		pff_pkg::entry_t  ranked [$];
		pff_pkg::entry_t  frontier [$];
		int               j;
		frontier_result_t res;

		if (held_entries.size() < SET_SIZE)
			held_entries.insert(held_entries.size(), ent);
		else
			held_overflow = 1'b1;
		if (!closes)
			return;

		// Insertion from the back, moving only past strictly later keys, so
		// earlier arrivals stay ahead of identical apex pairs.
		foreach (held_entries[i]) begin
			j = ranked.size();
			while (j > 0 && (held_entries[i].apex_first < ranked[j-1].apex_first ||
					(held_entries[i].apex_first == ranked[j-1].apex_first &&
					 held_entries[i].apex_second < ranked[j-1].apex_second)))
				j--;
			ranked.insert(j, held_entries[i]);
		end

		foreach (ranked[i]) begin
			if (frontier.size() == 0 ||
					ranked[i].apex_second < frontier[$].apex_second)
				frontier.insert(frontier.size(), ranked[i]);
		end

		if (log_results) begin
			foreach (frontier[i]) begin
				res.ent        = frontier[i];
				res.run_end    = (i == frontier.size() - 1);
				res.overflowed = held_overflow;
				frontier_due.insert(frontier_due.size(), res);
			end
		end

		sets_closed++;
		if (held_overflow)
			overflow_sets++;
		held_entries.delete();
		held_overflow = 1'b0;
	endfunction

	// Presents one input request after a random gap and waits for it to be
	// taken. The valid is only lowered when a gap follows, so a back-to-back
	// request never sees valid dropped and raised in the same step.
	task automatic offer_request(input pff_pkg::entry_t ent, input bit closes,
			input bit log_results);
		int unsigned gap;

		gap = draw_wait();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= ent;
		s_tlast  <= closes;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		requests_sent++;
		absorb_entry(ent, closes, log_results);
	endtask

	// Holds the input idle until every predicted result has been taken.
	task automatic drain_frontier();
		s_tvalid <= 1'b0;
		while (frontier_due.size() != 0)
			@(posedge clk);
	endtask

	// Output side: random stalls, then compare each taken request with the
	// oldest prediction.
	initial begin
		int unsigned      stall;
		frontier_result_t want;
		pff_pkg::entry_t  got;

		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait();
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			results_seen++;
			got = m_axis_tdata;
			if (frontier_due.size() == 0) begin
				$error("frontier result with none predicted: tdata %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = frontier_due.pop_front();
				if (got.apex_first !== want.ent.apex_first) begin
					$error("kept_apex_first: expected %h, got %h",
						want.ent.apex_first, got.apex_first);
					mismatches++;
				end
				if (got.apex_second !== want.ent.apex_second) begin
					$error("kept_apex_second: expected %h, got %h",
						want.ent.apex_second, got.apex_second);
					mismatches++;
				end
				if (got.cost_first !== want.ent.cost_first) begin
					$error("kept_cost_first: expected %h, got %h",
						want.ent.cost_first, got.cost_first);
					mismatches++;
				end
				if (got.cost_second !== want.ent.cost_second) begin
					$error("kept_cost_second: expected %h, got %h",
						want.ent.cost_second, got.cost_second);
					mismatches++;
				end
				if (m_axis_tlast !== want.run_end) begin
					$error("run_end: expected %b, got %b", want.run_end, m_axis_tlast);
					mismatches++;
				end
				if (m_axis_tuser !== want.overflowed) begin
					$error("overflowed: expected %b, got %b",
						want.overflowed, m_axis_tuser);
					mismatches++;
				end
			end
		end
	end

	// Stimulus: the directed table, then random sets, then the drain.
	initial begin
		pff_pkg::entry_t  ent;
		pff_pkg::entry_t  prev;
		frontier_result_t typed_res;
		spread_t          spread;
		int unsigned      set_len;
		int unsigned      pick;
		int unsigned      random_sent;
		int unsigned      random_sets;
		bit               closes;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			for (int unsigned k = 0; k < directed_rows[r].reps; k++) begin
				ent.apex_first  = directed_rows[r].a1;
				ent.apex_second = directed_rows[r].a2;
				ent.cost_first  = directed_rows[r].c1 ^ k;
				ent.cost_second = directed_rows[r].c2;
				closes = directed_rows[r].last && (k == directed_rows[r].reps - 1);
				if (closes && directed_rows[r].typed) begin
					typed_res.ent.apex_first  = directed_rows[r].w_a1;
					typed_res.ent.apex_second = directed_rows[r].w_a2;
					typed_res.ent.cost_first  = directed_rows[r].w_c1;
					typed_res.ent.cost_second = directed_rows[r].w_c2;
					typed_res.run_end         = 1'b1;
					typed_res.overflowed      = directed_rows[r].w_ovf;
					frontier_due.insert(frontier_due.size(), typed_res);
				end
				offer_request(ent, closes, !(closes && directed_rows[r].typed));
			end
		end

		// Hold off once with everything drained before the random part.
		drain_frontier();

		random_sent = 0;
		random_sets = 0;
		prev = '0;
		while (random_sent < RANDOM_REQS) begin
			// Mostly short sets; some fill the store exactly, a few overrun it.
			pick = $urandom_range(0, 99);
			if (pick < 70)
				set_len = $urandom_range(1, 8);
			else if (pick < 90)
				set_len = $urandom_range(9, SET_SIZE - 1);
			else if (pick < 95)
				set_len = SET_SIZE;
			else
				set_len = $urandom_range(SET_SIZE + 1, SET_SIZE + 8);
			spread = spread_t'($urandom_range(0, 3));
			steady = ($urandom_range(0, 4) == 0);
			if (random_sets % 8 == 7)
				drain_frontier();

			for (int unsigned k = 0; k < set_len; k++) begin
				if (spread == SPREAD_TRADEOFF) begin
					ent.apex_first  = $urandom_range(0, 1000);
					ent.apex_second = 1000 - ent.apex_first + $urandom_range(0, 3);
				end else begin
					ent.apex_first  = draw_apex(spread);
					ent.apex_second = draw_apex(spread);
				end
				// Now and then repeat the previous apex pair outright.
				if (k != 0 && $urandom_range(0, 5) == 0) begin
					ent.apex_first  = prev.apex_first;
					ent.apex_second = prev.apex_second;
				end
				ent.cost_first  = $urandom;
				ent.cost_second = $urandom;
				prev = ent;
				offer_request(ent, k == set_len - 1, 1'b1);
				random_sent++;
			end
			random_sets++;
		end

		steady = 1'b0;
		drain_frontier();
		// Room for a late, unpredicted result to show up.
		repeat (2 * SET_SIZE + 16) @(posedge clk);

		$display("summary: %0d requests in %0d sets, %0d of them over capacity",
			requests_sent, sets_closed, overflow_sets);
		$display("summary: %0d frontier results compared, %0d mismatches",
			results_seen, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Guard against a hung handshake: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
